@@ hdl/pdhr_pkg.sv @@
`default_nettype none

package pdhr_pkg;

   // Frame classification
   localparam logic [15:0] MIN_FRAME_BYTES = 16'd70;
   localparam logic [15:0] PROXY_OVERHEAD  = 16'd16;
   localparam logic [7:0]  PROTO_UDP       = 8'h11;
   localparam logic [7:0]  PROTO_TCP       = 8'h06;
   localparam logic [15:0] PORT_ZERO       = 16'd0;
   localparam logic [15:0] PORT_ONE        = 16'd1;

   // Width of a sum of up to five 16-bit terms
   localparam int unsigned SUM_W = 19;

   typedef enum logic [1:0] {
      ACT_PASS     = 2'd0,
      ACT_LOOPBACK = 2'd1,
      ACT_DECAP    = 2'd2
   } action_type;

   // Fold the carries once and complement; the carry of the fold is dropped
   function automatic logic [15:0] fold_once(input logic [SUM_W-1:0] s);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + 17'(s[SUM_W-1:16]);
      return ~t[15:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/proxy_decap_header_rewrite.sv @@
// Pipeline: an accepted request word reaches its response word through two registers
// (one input register, one result register).
// Throughput: one word per cycle while rsp_stall is low; the checksum path is a chain of
// 19-bit adds of 16-bit terms and folds between the two registers.
// Reset: synchronous, active high; clears only the valid flags.
`default_nettype none

module proxy_decap_header_rewrite
   import pdhr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_frame_length,
   input  wire logic [7:0]  req_ip_protocol,
   input  wire logic [15:0] req_udp_src_word,
   input  wire logic [15:0] req_udp_dst_word,
   input  wire logic [15:0] req_ip_total_len,
   input  wire logic [7:0]  req_ip_ttl,
   input  wire logic [15:0] req_ip_checksum,
   input  wire logic [31:0] req_ip_src_addr,
   input  wire logic [31:0] req_ip_dst_addr,
   input  wire logic [31:0] req_carried_src_addr,
   input  wire logic [31:0] req_carried_dst_addr,
   input  wire logic [15:0] req_tcp_checksum,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_action,
   output logic [15:0]      rsp_new_total_len,
   output logic [31:0]      rsp_new_src_addr,
   output logic [7:0]       rsp_new_protocol,
   output logic [15:0]      rsp_new_ip_checksum,
   output logic [15:0]      rsp_new_tcp_checksum
);

   // Input register
   logic        s1_valid_ff;
   logic [15:0] frame_length_ff;
   logic [7:0]  ip_protocol_ff;
   logic [15:0] udp_src_word_ff;
   logic [15:0] udp_dst_word_ff;
   logic [15:0] ip_total_len_ff;
   logic [7:0]  ip_ttl_ff;
   logic [15:0] ip_checksum_ff;
   logic [31:0] ip_src_addr_ff;
   logic [31:0] ip_dst_addr_ff;
   logic [31:0] carried_src_addr_ff;
   logic [31:0] carried_dst_addr_ff;
   logic [15:0] tcp_checksum_ff;

   // Result register
   logic        rsp_valid_ff;
   action_type  action_ff;
   logic [15:0] new_total_len_ff;
   logic [31:0] new_src_addr_ff;
   logic [7:0]  new_protocol_ff;
   logic [15:0] new_ip_checksum_ff;
   logic [15:0] new_tcp_checksum_ff;

   logic s1_load;
   logic s2_load;

   // Advance the result stage when it is empty or its word is taken
   assign s2_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   // Capture the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_load && req_valid) begin
         frame_length_ff     <= req_frame_length;
         ip_protocol_ff      <= req_ip_protocol;
         udp_src_word_ff     <= req_udp_src_word;
         udp_dst_word_ff     <= req_udp_dst_word;
         ip_total_len_ff     <= req_ip_total_len;
         ip_ttl_ff           <= req_ip_ttl;
         ip_checksum_ff      <= req_ip_checksum;
         ip_src_addr_ff      <= req_ip_src_addr;
         ip_dst_addr_ff      <= req_ip_dst_addr;
         carried_src_addr_ff <= req_carried_src_addr;
         carried_dst_addr_ff <= req_carried_dst_addr;
         tcp_checksum_ff     <= req_tcp_checksum;
      end
   end

   // Classify the frame
   logic       eligible;
   logic       loopback;
   logic       decap;
   action_type action_in;

   assign eligible = (frame_length_ff >= MIN_FRAME_BYTES) && (ip_protocol_ff == PROTO_UDP);
   assign loopback = eligible && (udp_src_word_ff == PORT_ZERO)
                     && (udp_dst_word_ff == PORT_ZERO);
   assign decap    = eligible && ((udp_src_word_ff != PORT_ZERO)
                     || (udp_dst_word_ff == PORT_ONE));

   always_comb begin
      if (decap) begin
         action_in = ACT_DECAP;
      end else if (loopback) begin
         action_in = ACT_LOOPBACK;
      end else begin
         action_in = ACT_PASS;
      end
   end

   // Incremental checksum updates
   logic [15:0]      nlen;
   logic [31:0]      saddr_n;
   logic [31:0]      csrc_n;
   logic [31:0]      cdst_n;
   logic [15:0]      proto_old_n;
   logic [15:0]      proto_new;
   logic [15:0]      ipck_n;
   logic [15:0]      tlen_n;
   logic [15:0]      ip_ck1_n;
   logic [15:0]      ip_ck2_n;
   logic [15:0]      tcpck_n;
   logic [15:0]      tcp_ck1_n;
   logic [SUM_W-1:0] ip_sum1;
   logic [SUM_W-1:0] ip_sum2;
   logic [SUM_W-1:0] ip_sum3;
   logic [SUM_W-1:0] tcp_sum1;
   logic [SUM_W-1:0] tcp_sum2;
   logic [15:0]      ip_ck1;
   logic [15:0]      ip_ck2;
   logic [15:0]      ip_ck_in;
   logic [15:0]      tcp_ck1;
   logic [15:0]      tcp_ck_in;

   assign nlen        = ip_total_len_ff - PROXY_OVERHEAD;
   assign saddr_n     = ~ip_src_addr_ff;
   assign csrc_n      = ~carried_src_addr_ff;
   assign cdst_n      = ~carried_dst_addr_ff;
   assign proto_old_n = ~{ip_ttl_ff, ip_protocol_ff};
   assign proto_new   = {ip_ttl_ff, PROTO_TCP};
   assign ipck_n      = ~ip_checksum_ff;
   assign tlen_n      = ~ip_total_len_ff;
   assign ip_ck1_n    = ~ip_ck1;
   assign ip_ck2_n    = ~ip_ck2;
   assign tcpck_n     = ~tcp_checksum_ff;
   assign tcp_ck1_n   = ~tcp_ck1;

   // IP: source address, then total length, then the ttl/protocol word
   assign ip_sum1 = SUM_W'(ipck_n) + SUM_W'(saddr_n[31:16]) + SUM_W'(saddr_n[15:0])
                    + SUM_W'(carried_src_addr_ff[31:16]) + SUM_W'(carried_src_addr_ff[15:0]);
   assign ip_ck1  = fold_once(ip_sum1);
   assign ip_sum2 = SUM_W'(ip_ck1_n) + SUM_W'(tlen_n) + SUM_W'(nlen);
   assign ip_ck2  = fold_once(ip_sum2);
   assign ip_sum3 = SUM_W'(ip_ck2_n) + SUM_W'(proto_old_n) + SUM_W'(proto_new);
   assign ip_ck_in = fold_once(ip_sum3);

   // TCP: carried source onto itself, then carried destination to outer destination
   assign tcp_sum1 = SUM_W'(tcpck_n) + SUM_W'(csrc_n[31:16]) + SUM_W'(csrc_n[15:0])
                     + SUM_W'(carried_src_addr_ff[31:16]) + SUM_W'(carried_src_addr_ff[15:0]);
   assign tcp_ck1  = fold_once(tcp_sum1);
   assign tcp_sum2 = SUM_W'(tcp_ck1_n) + SUM_W'(cdst_n[31:16]) + SUM_W'(cdst_n[15:0])
                     + SUM_W'(ip_dst_addr_ff[31:16]) + SUM_W'(ip_dst_addr_ff[15:0]);
   assign tcp_ck_in = fold_once(tcp_sum2);

   // Hold the result word until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s2_load && s1_valid_ff) begin
         action_ff <= action_in;
         if (decap) begin
            new_total_len_ff    <= nlen;
            new_src_addr_ff     <= carried_src_addr_ff;
            new_protocol_ff     <= PROTO_TCP;
            new_ip_checksum_ff  <= ip_ck_in;
            new_tcp_checksum_ff <= tcp_ck_in;
         end else begin
            new_total_len_ff    <= ip_total_len_ff;
            new_src_addr_ff     <= ip_src_addr_ff;
            new_protocol_ff     <= ip_protocol_ff;
            new_ip_checksum_ff  <= ip_checksum_ff;
            new_tcp_checksum_ff <= tcp_checksum_ff;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_action           = action_ff;
   assign rsp_new_total_len    = new_total_len_ff;
   assign rsp_new_src_addr     = new_src_addr_ff;
   assign rsp_new_protocol     = new_protocol_ff;
   assign rsp_new_ip_checksum  = new_ip_checksum_ff;
   assign rsp_new_tcp_checksum = new_tcp_checksum_ff;

`ifndef SYNTHESIS
   // Stall only when both stages are full and the output is blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // A decapsulated word always carries the TCP protocol
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (action_ff == ACT_DECAP)) |-> (new_protocol_ff == PROTO_TCP))
      else $error("decapsulated word without TCP protocol");

   // A decapsulated word carries the shortened total length
   assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_valid_ff && decap) |=>
         (new_total_len_ff == $past(ip_total_len_ff) - PROXY_OVERHEAD))
      else $error("total length not reduced by the proxy overhead");

   // A loopback word leaves the header untouched
   assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_valid_ff && loopback) |=>
         ((action_ff == ACT_LOOPBACK) && (new_ip_checksum_ff == $past(ip_checksum_ff))))
      else $error("loopback word altered");
`endif

endmodule

`default_nettype wire
